// ===== design/lcdfb_pkg.sv =====
// lcdfb_pkg: shared types and constants for the paged LCD framebuffer refresh unit.
// No dependencies.
package lcdfb_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // widest frame store address over the parameter range (16 pages x 256 columns)
  localparam int MAX_AW = 12;

  localparam logic [7:0] BYTE_PAGE = 8'b1011_1000;
  localparam logic [7:0] BYTE_ADDR = 8'b0100_0000;
  localparam logic [7:0] PAGE_MASK = 8'h07;
  localparam logic [6:0] LEVEL_MAX = 7'd100;

  // floor(p / 100) == (p * 5243) >> 19 for p below 43690
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    CMD_PIX_ON   = 3'd0,
    CMD_PIX_OFF  = 3'd1,
    CMD_PIX_READ = 3'd2,
    CMD_CLEAR    = 3'd3,
    CMD_BAR      = 3'd4,
    CMD_REFRESH  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SETUP,
    S_RD,
    S_WR,
    S_BAR_COL,
    S_REF_OUT
  } state_t;

  typedef enum logic [1:0] {
    BK_TOGGLE,
    BK_TOP,
    BK_BOT,
    BK_FINAL
  } bar_kind_t;

  typedef enum logic [1:0] {
    RP_HEAD0,
    RP_HEAD1,
    RP_BODY
  } ref_phase_t;

  typedef struct packed {
    logic              we;
    logic [MAX_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

endpackage

// ===== design/paged_lcd_framebuffer_refresh_unit.sv =====
// paged_lcd_framebuffer_refresh_unit: top level, command sequencer around the frame store.
// Depends on lcdfb_pkg and lcdfb_mem.
//
// Usage: a command transaction is taken at a rising edge with start high and busy low.
// Every command gives exactly one result, shown for one cycle with out_strobe high;
// the receiver cannot stall, so results must be taken when they appear.
// Timing, accept edge to the edge that takes the result (the next command may be
// taken in the strobe cycle):
//   refresh step         2 cycles (one frame store read)
//   pixel set/clear/read 4 + r cycles, r = modulo reduction steps of x, y and the bar box
//                        corner sums (the bar fields count for every command, 0 when in range)
//   bar graph            3 + r + w cycles plus 2 per pixel touched (read, then write back)
//   clear all            PAGES*COLUMNS + 1 cycles, one byte written per cycle
//   unknown command      1 cycle
// Store updates by pixel and bar commands are serialized read-then-write, S_RD then S_WR.
// Reset: after rst_n is released the store is swept to zero, PAGES*COLUMNS cycles
// (1024 at default size) with busy high. The refresh sequencer starts at its first
// word with both chip selects active.
module paged_lcd_framebuffer_refresh_unit #(
  parameter int COLUMNS = lcdfb_pkg::COLUMNS_DEF,
  parameter int PAGES   = lcdfb_pkg::PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_command,
  input  logic [6:0] in_x_coord,
  input  logic [5:0] in_y_coord,
  input  logic [7:0] in_bar_width,
  input  logic [6:0] in_bar_height,
  input  logic [6:0] in_bar_level,
  output logic       out_strobe,
  output logic       out_pixel_value,
  output logic       out_bus_valid,
  output logic       out_bus_rs,
  output logic       out_bus_cs_left,
  output logic       out_bus_cs_right,
  output logic [7:0] out_bus_byte,
  output logic       out_last_word
);
  import lcdfb_pkg::*;

  localparam int ROWS  = PAGES * 8;
  localparam int HALF  = COLUMNS / 2;
  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int KW    = $clog2(HALF + 1);

  state_t     state_r, state_nxt;
  logic [2:0] cmd_r, cmd_nxt;
  logic [7:0] w_r, w_nxt;
  logic [6:0] h_r, h_nxt;
  logic [8:0] xa_r, xa_nxt, xb_r, xb_nxt;
  logic [7:0] ya_r, ya_nxt, yb_r, yb_nxt;
  logic [14:0] prod_r, prod_nxt;
  logic [7:0] n_r, n_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [7:0] i_r, i_nxt;
  logic [6:0] j_r, j_nxt;
  bar_kind_t  kind_r, kind_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic       clr_cmd_r, clr_cmd_nxt;
  ref_phase_t phase_r, phase_nxt;
  logic       chip_r, chip_nxt;
  logic [PGW-1:0] page_r, page_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [1:0] cs_r, cs_nxt;

  logic       strobe_r, strobe_nxt;
  logic       pix_r, pix_nxt, valid_r, valid_nxt, rs_r, rs_nxt;
  logic       csl_r, csl_nxt, csr_r, csr_nxt, last_r, last_nxt;
  logic [7:0] byte_r, byte_nxt;

  mem_wr_t    wr;
  logic [AW-1:0] raddr, pix_addr, ref_addr;
  logic [7:0] rdata, mask, mod_byte;
  logic       accept, red_done, col_end, h_zero, j_end, ref_last, set_mode;
  logic [CW:0] col_p1;
  logic [RW:0] row_p1;
  logic [CW-1:0] col_wrap;
  logic [RW-1:0] row_wrap;
  logic [6:0] vsat;
  logic [27:0] nprod;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign red_done = (xa_r < 9'(COLUMNS)) && (xb_r < 9'(COLUMNS)) &&
                    (ya_r < 8'(ROWS)) && (yb_r < 8'(ROWS));
  assign col_end  = (i_r == w_r);
  assign h_zero   = (h_r == 7'd0);
  assign j_end    = (7'(j_r + 7'd1) == h_r);
  assign ref_last = chip_r && (page_r == PGW'(PAGES - 1)) && (k_r == KW'(HALF));

  assign col_p1   = {1'b0, col_r} + 1'b1;
  assign col_wrap = (col_p1 == (CW+1)'(COLUMNS)) ? '0 : col_p1[CW-1:0];
  assign row_p1   = {1'b0, row_r} + 1'b1;
  assign row_wrap = (row_p1 == (RW+1)'(ROWS)) ? '0 : row_p1[RW-1:0];

  assign vsat  = (in_bar_level > LEVEL_MAX) ? LEVEL_MAX : in_bar_level;
  assign nprod = 28'(prod_r) * 28'(RECIP_100);

  assign pix_addr = AW'(row_r >> 3) * AW'(COLUMNS) + AW'(col_r);
  assign ref_addr = AW'(page_r) * AW'(COLUMNS) + AW'(chip_r) * AW'(HALF) + AW'(k_r) - AW'(1);
  assign raddr    = (state_r == S_IDLE) ? ref_addr : pix_addr;

  assign mask     = 8'd1 << row_r[2:0];
  assign set_mode = (cmd_r == CMD_PIX_ON) || ((cmd_r == CMD_BAR) && (kind_r != BK_TOGGLE));
  always_comb begin
    if (set_mode) begin
      mod_byte = rdata | mask;
    end else if (cmd_r == CMD_PIX_OFF) begin
      mod_byte = rdata & ~mask;
    end else begin
      mod_byte = rdata ^ mask;
    end
  end

  always_comb begin
    wr = '0;
    if (state_r == S_CLEAR) begin
      wr.we   = 1'b1;
      wr.addr = MAX_AW'(clr_idx_r);
    end else if ((state_r == S_WR) && (cmd_r != CMD_PIX_READ)) begin
      wr.we   = 1'b1;
      wr.addr = MAX_AW'(pix_addr);
      wr.data = mod_byte;
    end
  end

  lcdfb_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority case (in_command)
            CMD_PIX_ON, CMD_PIX_OFF, CMD_PIX_READ, CMD_BAR: state_nxt = S_SETUP;
            CMD_CLEAR:   state_nxt = S_CLEAR;
            CMD_REFRESH: state_nxt = S_REF_OUT;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR:   if (clr_idx_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_SETUP:   if (red_done) state_nxt = (cmd_r == CMD_BAR) ? S_BAR_COL : S_RD;
      S_RD:      state_nxt = S_WR;
      S_WR: begin
        if (cmd_r != CMD_BAR) begin
          state_nxt = S_IDLE;
        end else begin
          unique case (kind_r)
            BK_TOGGLE: state_nxt = j_end ? S_BAR_COL : S_RD;
            BK_TOP:    state_nxt = S_RD;
            BK_BOT:    state_nxt = S_BAR_COL;
            BK_FINAL:  state_nxt = j_end ? S_IDLE : S_RD;
          endcase
        end
      end
      S_BAR_COL: begin
        if (col_end) begin
          state_nxt = h_zero ? S_IDLE : S_RD;
        end else if (!h_zero) begin
          state_nxt = S_RD;
        end
      end
      S_REF_OUT: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    cmd_nxt = cmd_r;  w_nxt = w_r;  h_nxt = h_r;
    xa_nxt = xa_r;  xb_nxt = xb_r;  ya_nxt = ya_r;  yb_nxt = yb_r;
    prod_nxt = prod_r;  n_nxt = n_r;
    col_nxt = col_r;  row_nxt = row_r;  i_nxt = i_r;  j_nxt = j_r;  kind_nxt = kind_r;
    clr_idx_nxt = clr_idx_r;  clr_cmd_nxt = clr_cmd_r;
    phase_nxt = phase_r;  chip_nxt = chip_r;  page_nxt = page_r;  k_nxt = k_r;
    cs_nxt = cs_r;
    strobe_nxt = 1'b0;  pix_nxt = 1'b0;  valid_nxt = 1'b0;  rs_nxt = 1'b0;
    csl_nxt = 1'b0;  csr_nxt = 1'b0;  byte_nxt = 8'd0;  last_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_command;
          w_nxt    = in_bar_width;
          h_nxt    = in_bar_height;
          xa_nxt   = 9'(in_x_coord);
          xb_nxt   = 9'(in_x_coord) + 9'(8'(in_bar_width - 8'd1));
          ya_nxt   = 8'(in_y_coord);
          yb_nxt   = 8'(8'(in_y_coord) + 8'(in_bar_height) - 8'd1);
          prod_nxt = 15'(vsat) * 15'(in_bar_width);
          clr_idx_nxt = '0;
          clr_cmd_nxt = 1'b1;
          if (in_command == CMD_REFRESH) begin
            strobe_nxt = 1'b1;
          end else if ((in_command != CMD_PIX_ON) && (in_command != CMD_PIX_OFF) &&
                       (in_command != CMD_PIX_READ) && (in_command != CMD_BAR) &&
                       (in_command != CMD_CLEAR)) begin
            strobe_nxt = 1'b1;  // unknown command: all-zero result
          end
          // refresh result is formed in S_REF_OUT; drop the early strobe there
          if (in_command == CMD_REFRESH) strobe_nxt = 1'b0;
        end
      end
      S_CLEAR: begin
        clr_idx_nxt = AW'(clr_idx_r + 1'b1);
        if (clr_idx_r == AW'(DEPTH - 1)) begin
          strobe_nxt  = clr_cmd_r;
          clr_cmd_nxt = 1'b0;
        end
      end
      S_SETUP: begin
        n_nxt = nprod[RECIP_SHIFT +: 8];
        if (xa_r >= 9'(COLUMNS)) xa_nxt = xa_r - 9'(COLUMNS);
        if (xb_r >= 9'(COLUMNS)) xb_nxt = xb_r - 9'(COLUMNS);
        if (ya_r >= 8'(ROWS))    ya_nxt = ya_r - 8'(ROWS);
        if (yb_r >= 8'(ROWS))    yb_nxt = yb_r - 8'(ROWS);
        if (red_done) begin
          col_nxt = xa_r[CW-1:0];
          row_nxt = ya_r[RW-1:0];
          i_nxt   = 8'd0;
        end
      end
      S_RD: ;
      S_WR: begin
        if (cmd_r != CMD_BAR) begin
          strobe_nxt = 1'b1;
          pix_nxt    = (cmd_r == CMD_PIX_READ) ? rdata[row_r[2:0]] : 1'b0;
        end else begin
          unique case (kind_r)
            BK_TOGGLE: begin
              if (j_end) begin
                i_nxt   = 8'(i_r + 8'd1);
                col_nxt = col_wrap;
              end else begin
                j_nxt   = 7'(j_r + 7'd1);
                row_nxt = row_wrap;
              end
            end
            BK_TOP: begin
              kind_nxt = BK_BOT;
              row_nxt  = yb_r[RW-1:0];
            end
            BK_BOT: begin
              i_nxt   = 8'(i_r + 8'd1);
              col_nxt = col_wrap;
            end
            BK_FINAL: begin
              if (j_end) begin
                strobe_nxt = 1'b1;
              end else begin
                j_nxt   = 7'(j_r + 7'd1);
                row_nxt = row_wrap;
              end
            end
          endcase
        end
      end
      S_BAR_COL: begin
        j_nxt   = 7'd0;
        row_nxt = ya_r[RW-1:0];
        if (col_end) begin
          kind_nxt   = BK_FINAL;
          col_nxt    = xb_r[CW-1:0];
          strobe_nxt = h_zero;
        end else if (!h_zero) begin
          kind_nxt = (i_r < n_r) ? BK_TOGGLE : BK_TOP;
        end else begin
          i_nxt   = 8'(i_r + 8'd1);
          col_nxt = col_wrap;
        end
      end
      S_REF_OUT: begin
        strobe_nxt = 1'b1;
        valid_nxt  = 1'b1;
        unique case (phase_r)
          RP_HEAD0: begin
            byte_nxt  = BYTE_PAGE;
            csl_nxt   = cs_r[0];
            csr_nxt   = cs_r[1];
            phase_nxt = RP_HEAD1;
          end
          RP_HEAD1: begin
            byte_nxt  = BYTE_ADDR;
            csl_nxt   = cs_r[0];
            csr_nxt   = cs_r[1];
            phase_nxt = RP_BODY;
            chip_nxt  = 1'b0;
            page_nxt  = '0;
            k_nxt     = '0;
          end
          RP_BODY: begin
            cs_nxt  = chip_r ? 2'b10 : 2'b01;
            csl_nxt = !chip_r;
            csr_nxt = chip_r;
            if (k_r == '0) begin
              byte_nxt = BYTE_PAGE + (8'(page_r) & PAGE_MASK);
            end else begin
              rs_nxt   = 1'b1;
              byte_nxt = rdata;
            end
            last_nxt = ref_last;
            if (k_r == KW'(HALF)) begin
              k_nxt = '0;
              if (page_r == PGW'(PAGES - 1)) begin
                page_nxt = '0;
                if (chip_r) phase_nxt = RP_HEAD0;
                else        chip_nxt  = 1'b1;
              end else begin
                page_nxt = PGW'(page_r + 1'b1);
              end
            end else begin
              k_nxt = KW'(k_r + 1'b1);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      clr_cmd_r <= 1'b0;
      phase_r   <= RP_HEAD0;
      chip_r    <= 1'b0;
      page_r    <= '0;
      k_r       <= '0;
      cs_r      <= 2'b11;
      strobe_r  <= 1'b0;
      pix_r     <= 1'b0;
      valid_r   <= 1'b0;
      rs_r      <= 1'b0;
      csl_r     <= 1'b0;
      csr_r     <= 1'b0;
      byte_r    <= 8'd0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      clr_cmd_r <= clr_cmd_nxt;
      phase_r   <= phase_nxt;
      chip_r    <= chip_nxt;
      page_r    <= page_nxt;
      k_r       <= k_nxt;
      cs_r      <= cs_nxt;
      strobe_r  <= strobe_nxt;
      pix_r     <= pix_nxt;
      valid_r   <= valid_nxt;
      rs_r      <= rs_nxt;
      csl_r     <= csl_nxt;
      csr_r     <= csr_nxt;
      byte_r    <= byte_nxt;
      last_r    <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    xa_r   <= xa_nxt;
    xb_r   <= xb_nxt;
    ya_r   <= ya_nxt;
    yb_r   <= yb_nxt;
    prod_r <= prod_nxt;
    n_r    <= n_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    kind_r <= kind_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_pixel_value  = pix_r;
  assign out_bus_valid    = valid_r;
  assign out_bus_rs       = rs_r;
  assign out_bus_cs_left  = csl_r;
  assign out_bus_cs_right = csr_r;
  assign out_bus_byte     = byte_r;
  assign out_last_word    = last_r;

endmodule

// ===== design/lcdfb_mem.sv =====
// lcdfb_mem: frame store, one write port and one registered read port.
// Depends on lcdfb_pkg (mem_wr_t).
module lcdfb_mem #(
  parameter int DEPTH = lcdfb_pkg::COLUMNS_DEF * lcdfb_pkg::PAGES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  lcdfb_pkg::mem_wr_t wr,
  input  logic [AW-1:0]     raddr,
  output logic [7:0]        rdata
);
  import lcdfb_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/lcdfb_checker.sv =====
// lcdfb_checker: port-level assertions for the framebuffer refresh unit, bound to the top.
// Depends on lcdfb_pkg (command codes) and paged_lcd_framebuffer_refresh_unit.
module lcdfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_command,
  input logic       out_strobe,
  input logic       out_pixel_value,
  input logic       out_bus_valid,
  input logic       out_bus_cs_left,
  input logic       out_bus_cs_right,
  input logic       out_last_word
);
  import lcdfb_pkg::*;

  // store sweep keeps the block busy right after reset
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  a_refresh_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_REFRESH) |=> busy ##1 (out_strobe && out_bus_valid))
    else $error("refresh word not delivered two cycles after accept");

  a_bus_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus_valid || out_pixel_value) |-> out_strobe)
    else $error("result field set without strobe");

  a_pixel_no_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_pixel_value |-> !out_bus_valid)
    else $error("pixel read result carries a bus word");

  a_last_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_word |-> (out_bus_valid && out_bus_cs_right && !out_bus_cs_left))
    else $error("last word not on right chip");

endmodule

bind paged_lcd_framebuffer_refresh_unit lcdfb_checker u_lcdfb_checker (.*);

// ===== verif/lcdfb_checker.sv =====
// lcdfb_scoreboard: watches the command and result channels of the LCD framebuffer unit,
// keeps its own copy of the frame store and refresh sequencer, and compares every result.
// Depends on lcdfb_pkg.
module lcdfb_scoreboard (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] in_command,
  input  logic [6:0] in_x_coord,
  input  logic [5:0] in_y_coord,
  input  logic [7:0] in_bar_width,
  input  logic [6:0] in_bar_height,
  input  logic [6:0] in_bar_level,
  input  logic       out_strobe,
  input  logic       out_pixel_value,
  input  logic       out_bus_valid,
  input  logic       out_bus_rs,
  input  logic       out_bus_cs_left,
  input  logic       out_bus_cs_right,
  input  logic [7:0] out_bus_byte,
  input  logic       out_last_word,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcdfb_pkg::*;

  localparam int NCOL       = COLUMNS_DEF;
  localparam int NROW       = PAGES_DEF * 8;
  localparam int HALF       = NCOL / 2;
  localparam int PAGE_WORDS = 1 + HALF;
  localparam int CHIP_WORDS = PAGES_DEF * PAGE_WORDS;
  localparam int PASS_WORDS = 2 + 2 * CHIP_WORDS;

  typedef struct packed {
    logic       pixel_value;
    logic       bus_valid;
    logic       bus_rs;
    logic       cs_left;
    logic       cs_right;
    logic [7:0] bus_byte;
    logic       last_word;
  } lcd_result_t;

  logic [7:0]  fb [PAGES_DEF][NCOL];
  int          word_pos;
  logic [1:0]  cs_latch;
  lcd_result_t expected_q[$];

  assign pending = expected_q.size();

  // mode: 0 set, 1 clear, 2 toggle
  function automatic void pixel_update(int x, int y, int mode);
    int col;
    int row;
    col = x % NCOL;
    row = y % NROW;
    case (mode)
      0: fb[row / 8][col][row % 8] = 1'b1;
      1: fb[row / 8][col][row % 8] = 1'b0;
      default: fb[row / 8][col][row % 8] = ~fb[row / 8][col][row % 8];
    endcase
  endfunction

  function automatic void draw_bar(int x, int y, int w, int h, int v);
    int n;
    int last_col;
    if (v > 100) v = 100;
    n = v * w / 100;
    for (int i = 0; i < w; i++) begin
      if (i < n) begin
        for (int j = 0; j < h; j++) pixel_update(x + i, y + j, 2);
      end else if (h > 0) begin
        pixel_update(x + i, y, 0);
        pixel_update(x + i, y + h - 1, 0);
      end
    end
    last_col = (w + 255) & 8'hFF;
    for (int j = 0; j < h; j++) pixel_update(x + last_col, y + j, 0);
  endfunction

  function automatic lcd_result_t predict_lcd(logic [2:0] cmd, int x, int y, int w, int h,
                                              int v);
    lcd_result_t r;
    int pos, idx, chip, chip_ofs, page, k;
    r = '0;
    case (cmd)
      CMD_PIX_ON:   pixel_update(x, y, 0);
      CMD_PIX_OFF:  pixel_update(x, y, 1);
      CMD_PIX_READ: r.pixel_value = fb[(y % NROW) / 8][x % NCOL][(y % NROW) % 8];
      CMD_CLEAR: begin
        foreach (fb[p, c]) fb[p][c] = '0;
      end
      CMD_BAR:      draw_bar(x, y, w, h, v);
      CMD_REFRESH: begin
        pos = word_pos;
        r.bus_valid = 1'b1;
        if (pos >= PASS_WORDS) pos = 0;
        if (pos == 0) r.bus_byte = BYTE_PAGE;
        else if (pos == 1) r.bus_byte = BYTE_ADDR;
        else begin
          idx      = pos - 2;
          chip     = idx / CHIP_WORDS;
          chip_ofs = idx % CHIP_WORDS;
          page     = chip_ofs / PAGE_WORDS;
          k        = chip_ofs % PAGE_WORDS;
          cs_latch = chip ? 2'b10 : 2'b01;
          if (k == 0) r.bus_byte = BYTE_PAGE + 8'(page & PAGE_MASK);
          else begin
            r.bus_rs   = 1'b1;
            r.bus_byte = fb[page][chip * HALF + k - 1];
          end
        end
        r.cs_left  = cs_latch[0];
        r.cs_right = cs_latch[1];
        if (pos == PASS_WORDS - 1) begin
          r.last_word = 1'b1;
          word_pos = 0;
        end else word_pos = pos + 1;
      end
      default: ;
    endcase
    return r;
  endfunction

  lcd_result_t seen, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (fb[p, c]) fb[p][c] = '0;
      word_pos   = 0;
      cs_latch   = 2'b11;
      fail_count = 0;
      expected_q.delete();
    end else begin
      // result first: a strobe in the accept cycle belongs to the previous transaction
      if (out_strobe) begin
        seen = '{out_pixel_value, out_bus_valid, out_bus_rs, out_bus_cs_left,
                 out_bus_cs_right, out_bus_byte, out_last_word};
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: unexpected result %p", $realtime, seen);
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch expected %p actual %p", $realtime, want, seen);
          end
        end
      end
      if (start && !busy)
        expected_q.push_back(predict_lcd(in_command, in_x_coord, in_y_coord, in_bar_width,
                                         in_bar_height, in_bar_level));
    end
  end
endmodule

// ===== verif/tb.sv =====
// tb: stimulus and verdict for paged_lcd_framebuffer_refresh_unit.
// Depends on lcdfb_pkg, lcdfb_scoreboard and the unit itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdfb_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_command = '0;
  logic [6:0] in_x_coord = '0;
  logic [5:0] in_y_coord = '0;
  logic [7:0] in_bar_width = 8'd1;
  logic [6:0] in_bar_height = 7'd1;
  logic [6:0] in_bar_level = '0;
  logic       out_strobe, out_pixel_value, out_bus_valid, out_bus_rs;
  logic       out_bus_cs_left, out_bus_cs_right, out_last_word;
  logic [7:0] out_bus_byte;
  int         fail_count, pending, quiet_cycles;

  paged_lcd_framebuffer_refresh_unit DUT (.*);
  lcdfb_scoreboard u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog: cycles in which no transaction moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic issue(cmd_t cmd, int x, int y, int w, int h, int v);
    start         <= 1'b1;
    in_command    <= cmd;
    in_x_coord    <= 7'(x);
    in_y_coord    <= 6'(y);
    in_bar_width  <= 8'(w);
    in_bar_height <= 7'(h);
    in_bar_level  <= 7'(v);
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic random_cmd();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) issue(CMD_REFRESH, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (pick < 60) issue(CMD_PIX_ON, $urandom_range(127), $urandom_range(63), 1, 1, 0);
    else if (pick < 72) issue(CMD_PIX_OFF, $urandom_range(127), $urandom_range(63), 1, 1, 0);
    else if (pick < 85) issue(CMD_PIX_READ, $urandom_range(127), $urandom_range(63), 1, 1, 0);
    else if (pick < 87) issue(CMD_CLEAR, $urandom_range(127), $urandom_range(63), 1, 1, 0);
    else if (pick < 98)
      issue(CMD_BAR, $urandom_range(127), $urandom_range(63), $urandom_range(1, 16),
            $urandom_range(1, 8), $urandom_range(100));
    else
      issue(CMD_BAR, $urandom_range(127), $urandom_range(63), $urandom_range(1, 128),
            $urandom_range(1, 64), $urandom_range(100));
  endtask

  initial begin
    int sent, burst;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corners, wrap of the bar box, every command
    issue(CMD_PIX_ON, 0, 0, 1, 1, 0);
    issue(CMD_PIX_ON, 127, 63, 1, 1, 0);
    issue(CMD_PIX_READ, 0, 0, 1, 1, 0);
    issue(CMD_PIX_READ, 127, 63, 1, 1, 0);
    issue(CMD_PIX_READ, 5, 5, 1, 1, 0);
    issue(CMD_PIX_OFF, 127, 63, 1, 1, 0);
    issue(CMD_PIX_READ, 127, 63, 1, 1, 0);
    issue(CMD_REFRESH, 0, 0, 1, 1, 0);
    issue(CMD_REFRESH, 0, 0, 1, 1, 0);
    issue(CMD_REFRESH, 0, 0, 1, 1, 0);
    issue(CMD_BAR, 0, 0, 1, 1, 0);
    issue(CMD_BAR, 120, 60, 10, 5, 50);
    issue(CMD_BAR, 127, 63, 128, 64, 100);
    issue(CMD_BAR, 64, 32, 128, 1, 0);
    issue(CMD_BAR, 3, 7, 3, 64, 100);
    issue(CMD_BAR, 90, 10, 40, 20, 99);
    issue(CMD_PIX_READ, 127, 0, 1, 1, 0);
    issue(CMD_REFRESH, 0, 0, 1, 1, 0);
    issue(CMD_CLEAR, 0, 0, 1, 1, 0);
    issue(CMD_PIX_READ, 0, 0, 1, 1, 0);
    issue(CMD_REFRESH, 127, 63, 128, 64, 100);
    pause(3);

    sent = 0;
    while (sent < 1950) begin
      burst = $urandom_range(1, 20);
      repeat (burst) random_cmd();
      sent += burst;
      if ($urandom_range(3) != 0) pause($urandom_range(1, 8));
    end
    pause(0);

    // let the checker log the last transaction before looking at its queue
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== files.f =====
design/lcdfb_pkg.sv
design/lcdfb_mem.sv
design/paged_lcd_framebuffer_refresh_unit.sv
design/lcdfb_checker.sv
verif/lcdfb_checker.sv
verif/tb.sv
